// ----- hdl/pcd_pkg.sv -----
package pcd_pkg;

    localparam int NUM_CODES = 32;

    // Input request: one byte and its end-of-line flag
    typedef struct packed {
        logic [7:0] char_in;
        logic       line_last;
    } t_in;

    // Output request: one decoded result
    typedef struct packed {
        logic [6:0] char_out;
        logic       has_char;
        logic       line_end;
        logic       last_of_run;
    } t_out;

    // Bits carried by one byte
    typedef struct packed {
        logic       vld;
        logic [4:0] sym;
    } t_sym;

    // Result of a table lookup
    typedef struct packed {
        logic       hit;
        logic [6:0] chr;
    } t_match;

    // Prefix code table: right-aligned code, its length, its character
    localparam logic [7:0] CODE_VAL [NUM_CODES] = '{
        8'h05, 8'h00, 8'h03, 8'h91, 8'h11, 8'h01, 8'h25, 8'h9A,
        8'h05, 8'h01, 8'h06, 8'h09, 8'h9B, 8'h10, 8'h07, 8'h98,
        8'h06, 8'h04, 8'h99, 8'h9E, 8'h05, 8'h07, 8'h9F, 8'h08,
        8'h06, 8'h07, 8'h9C, 8'h9D, 8'h02, 8'h92, 8'h93, 8'h90
    };
    localparam logic [3:0] CODE_LEN [NUM_CODES] = '{
        4'd3, 4'd6, 4'd6, 4'd8, 4'd6, 4'd6, 4'd6, 4'd8,
        4'd4, 4'd4, 4'd3, 4'd5, 4'd8, 4'd6, 4'd4, 4'd8,
        4'd4, 4'd5, 4'd8, 4'd8, 4'd5, 4'd3, 4'd8, 4'd4,
        4'd5, 4'd5, 4'd8, 4'd8, 4'd6, 4'd8, 4'd8, 4'd8
    };
    localparam logic [6:0] CODE_CHR [NUM_CODES] = '{
        7'h20, 7'h27, 7'h2C, 7'h2D, 7'h2E, 7'h3F, 7'h41, 7'h42,
        7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4A,
        7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52,
        7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A
    };

    // Map a byte to its 5-bit symbol
    function automatic t_sym symbol_of(input logic [7:0] c);
        t_sym s;
        s.vld = 1'b1;
        s.sym = 5'd0;
        case (c) inside
            [8'h41:8'h5A]: s.sym = 5'(c - 8'h41);
            8'h20:         s.sym = 5'd26;
            8'h2E:         s.sym = 5'd27;
            8'h2C:         s.sym = 5'd28;
            8'h2D:         s.sym = 5'd29;
            8'h27:         s.sym = 5'd30;
            8'h3F:         s.sym = 5'd31;
            default:       s.vld = 1'b0;
        endcase
        return s;
    endfunction

    // Match a pending string of given length against the table
    function automatic t_match code_match(input logic [7:0] bits, input logic [3:0] len);
        t_match m;
        m.hit = 1'b0;
        m.chr = 7'd0;
        for (int k = 0; k < NUM_CODES; k++) begin
            if (CODE_LEN[k] == len && CODE_VAL[k] == bits) begin
                m.hit = 1'b1;
                m.chr = CODE_CHR[k];
            end
        end
        return m;
    endfunction

endpackage

// ----- hdl/five_bit_to_prefix_code_decoder_unit.sv -----
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_in_data  (pcd_pkg::t_in)
// output    out        o_out_valid / i_out_stall  o_out_data (pcd_pkg::t_out)
//
// One byte is accepted per cycle while o_in_stall is low; a byte that decodes two
// characters holds the result slot until both are taken, so throughput is set by the output port.
// A byte passes through the input register, then one decode pass into the
// result slot.
// Reset (synchronous, active low) empties both stages and clears pending bits.
// A stalled output holds the slot; the input register still takes one byte.
module five_bit_to_prefix_code_decoder_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pcd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pcd_pkg::t_out o_out_data
);

    logic          r_in_vld;
    pcd_pkg::t_in  r_in;
    logic [6:0]    r_pend_bits;
    logic [2:0]    r_pend_cnt;
    pcd_pkg::t_out r_res [2];
    logic [1:0]    r_cnt;
    logic          r_sel;

    pcd_pkg::t_out n_res0;
    pcd_pkg::t_out n_res1;
    logic [1:0]    n_nres;
    logic [6:0]    n_pend_bits;
    logic [2:0]    n_pend_cnt;

    logic in_acc;
    logic out_acc;
    logic out_last;
    logic slot_free;
    logic move;

    // Decode the held byte against the pending bits, one bit a step
    always_comb begin
        pcd_pkg::t_sym   s;
        pcd_pkg::t_match m;
        logic [7:0]      bits;
        logic [3:0]      cnt;
        s      = pcd_pkg::symbol_of(r_in.char_in);
        m      = '0;
        bits   = {1'b0, r_pend_bits};
        cnt    = {1'b0, r_pend_cnt};
        n_nres = 2'd0;
        n_res0 = '0;
        n_res1 = '0;
        if (s.vld) begin
            for (int b = 4; b >= 0; b--) begin
                bits = {bits[6:0], s.sym[3'(b)]};
                cnt  = cnt + 4'd1;
                m    = pcd_pkg::code_match(bits, cnt);
                if (m.hit) begin
                    if (n_nres == 2'd0) begin
                        n_res0.char_out = m.chr;
                        n_res0.has_char = 1'b1;
                    end else begin
                        n_res1.char_out = m.chr;
                        n_res1.has_char = 1'b1;
                    end
                    n_nres = n_nres + 2'd1;
                    bits   = 8'd0;
                    cnt    = 4'd0;
                end else if (cnt >= 4'd8) begin
                    bits = 8'd0;
                    cnt  = 4'd0;
                end
            end
        end
        // Drop unfinished bits at line end and flag the final result
        if (r_in.line_last) begin
            bits = 8'd0;
            cnt  = 4'd0;
            if (n_nres == 2'd0) begin
                n_res0.line_end = 1'b1;
                n_nres          = 2'd1;
            end else if (n_nres == 2'd1) begin
                n_res0.line_end = 1'b1;
            end else begin
                n_res1.line_end = 1'b1;
            end
        end
        if (n_nres == 2'd1) begin
            n_res0.last_of_run = 1'b1;
        end
        if (n_nres == 2'd2) begin
            n_res1.last_of_run = 1'b1;
        end
        n_pend_bits = bits[6:0];
        n_pend_cnt  = cnt[2:0];
    end

    // Handshake control
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_res[r_sel];
    assign out_acc     = o_out_valid && !i_out_stall;
    assign out_last    = r_res[r_sel].last_of_run;
    assign slot_free   = (r_cnt == 2'd0) || (out_acc && out_last);
    assign move        = r_in_vld && ((n_nres == 2'd0) || slot_free);
    assign o_in_stall  = r_in_vld && !move;
    assign in_acc      = i_in_valid && !o_in_stall;

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_pend_bits <= 7'd0;
            r_pend_cnt  <= 3'd0;
            r_cnt       <= 2'd0;
            r_sel       <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (move) begin
                r_in_vld <= 1'b0;
            end
            if (move) begin
                r_pend_bits <= n_pend_bits;
                r_pend_cnt  <= n_pend_cnt;
            end
            // Load a new run, else step through the held one
            if (move && n_nres != 2'd0) begin
                r_cnt <= n_nres;
                r_sel <= 1'b0;
            end else if (out_acc) begin
                if (out_last) begin
                    r_cnt <= 2'd0;
                end else begin
                    r_sel <= 1'b1;
                end
            end
        end
    end

    // Hold input and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (move && n_nres != 2'd0) begin
            r_res[0] <= n_res0;
            r_res[1] <= n_res1;
        end
    end

endmodule
